@@ hw/rtl/udrb_pkg.sv @@
`timescale 1ns / 1ps

package udrb_pkg;

  localparam int unsigned RingDepthDefault = 8;
  localparam int unsigned CmdW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LevelW = 4;

  typedef enum logic [CmdW-1:0] {
    CmdPut      = 3'd0,
    CmdGet      = 3'd1,
    CmdTxReady  = 3'd2,
    CmdRxArrive = 3'd3,
    CmdFlushRx  = 3'd4,
    CmdFlushTx  = 3'd5
  } udrb_cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } udrb_ring_req_t;

  typedef struct packed {
    logic            [CmdW-1:0] cmd;
    logic                       ok;
    logic                       over;
    logic                       rd_rx;
    logic                       rd_tx;
  } udrb_pend_t;

endpackage

@@ hw/rtl/udrb_if.sv @@
`timescale 1ns / 1ps

interface udrb_in_if;
  logic                       valid;
  logic                       ready;
  logic [udrb_pkg::CmdW-1:0]  command;
  logic [udrb_pkg::ByteW-1:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink (input valid, input command, input data_in, output ready);
endinterface

interface udrb_out_if;
  logic                        valid;
  logic                        ready;
  logic [udrb_pkg::ByteW-1:0]  data_out;
  logic                        ok;
  logic                        rx_overwrote;
  logic                        tx_active;
  logic [udrb_pkg::LevelW-1:0] rx_level;
  logic [udrb_pkg::LevelW-1:0] tx_level;

  modport source (
    output valid, output data_out, output ok, output rx_overwrote,
    output tx_active, output rx_level, output tx_level, input ready
  );
  modport sink (
    input valid, input data_out, input ok, input rx_overwrote,
    input tx_active, input rx_level, input tx_level, output ready
  );
endinterface

@@ hw/rtl/udrb_ring.sv @@
`timescale 1ns / 1ps

module udrb_ring #(
  parameter int unsigned RING_DEPTH = udrb_pkg::RingDepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  udrb_pkg::udrb_ring_req_t              req_i,
  input  logic [udrb_pkg::ByteW-1:0]            wdata_i,
  output logic [udrb_pkg::ByteW-1:0]            rdata_o,
  output logic [$clog2(RING_DEPTH+1)-1:0]       fill_o,
  output logic                                  full_o,
  output logic                                  empty_o
);
  import udrb_pkg::*;

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);

  logic [ByteW-1:0] mem [RING_DEPTH];
  logic [ByteW-1:0] rdata_q;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (fill_q == FillW'(RING_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = req_i.push;
  assign do_pop  = req_i.pop && !empty_o;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (req_i.flush) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end else if (do_push) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
      if (full_o) begin
        rd_ptr_d = ptr_next(rd_ptr_q);
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (do_pop) begin
      rd_ptr_d = ptr_next(rd_ptr_q);
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push && !req_i.flush) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    if (do_pop && !req_i.flush && !do_push) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;
  assign fill_o  = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RING_DEPTH))
    else $error("Ring fill count exceeds the ring depth.");

  a_ptr_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (rd_ptr_q == wr_ptr_q))
    else $error("Ring pointers disagree with an empty or full ring.");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !req_i.push && !req_i.flush) |=> (fill_q == $past(fill_q) - 1'b1))
    else $error("A pop did not lower the fill count by one.");

endmodule

@@ hw/rtl/uart_dual_ring_buffer_core.sv @@
`timescale 1ns / 1ps
// A request moves through the pending register, then the output register.
// Throughput: one request per cycle, set by the registered memory read
// followed by the output register; a stalled output holds the input off.
// Reset: ring pointers, fill counts, the transmit-active flag and the pipeline
// valid bits clear at once; ring contents are not cleared.
module uart_dual_ring_buffer_core #(
  parameter int unsigned RING_DEPTH = udrb_pkg::RingDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  udrb_in_if.sink     in_i,
  udrb_out_if.source  out_o
);
  import udrb_pkg::*;

  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);

  udrb_ring_req_t   rx_req, tx_req;
  logic [ByteW-1:0] rx_rdata, tx_rdata;
  logic [FillW-1:0] rx_fill, tx_fill;
  logic             rx_full, rx_empty, tx_full, tx_empty;

  udrb_pend_t       pend_d, pend_q;
  logic             pend_valid_q;
  logic             out_valid_q;
  logic             tx_en_q, tx_en_d;
  logic             advance, accept;

  logic [ByteW-1:0]  data_q;
  logic              ok_q, over_q, tx_active_q;
  logic [LevelW-1:0] rx_level_q, tx_level_q;
  logic [FillW+LevelW-1:0] rx_fill_ext, tx_fill_ext;

  udrb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rx_req),
    .wdata_i (in_i.data_in),
    .rdata_o (rx_rdata),
    .fill_o  (rx_fill),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  udrb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tx_req),
    .wdata_i (in_i.data_in),
    .rdata_o (tx_rdata),
    .fill_o  (tx_fill),
    .full_o  (tx_full),
    .empty_o (tx_empty)
  );

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;

  always_comb begin
    rx_req      = '0;
    tx_req      = '0;
    tx_en_d     = tx_en_q;
    pend_d      = '0;
    pend_d.cmd  = in_i.command;
    if (accept) begin
      case (in_i.command)
        CmdPut: begin
          if (!tx_full) begin
            tx_req.push = 1'b1;
            tx_en_d     = 1'b1;
            pend_d.ok   = 1'b1;
          end
        end
        CmdGet: begin
          if (!rx_empty) begin
            rx_req.pop   = 1'b1;
            pend_d.ok    = 1'b1;
            pend_d.rd_rx = 1'b1;
          end
        end
        CmdTxReady: begin
          if (!tx_empty) begin
            tx_req.pop   = 1'b1;
            pend_d.ok    = 1'b1;
            pend_d.rd_tx = 1'b1;
          end
          if (tx_empty || (tx_fill == FillW'(1))) begin
            tx_en_d = 1'b0;
          end
        end
        CmdRxArrive: begin
          rx_req.push = 1'b1;
          pend_d.over = rx_full;
        end
        CmdFlushRx: rx_req.flush = 1'b1;
        CmdFlushTx: tx_req.flush = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tx_en_q      <= 1'b0;
    end else begin
      tx_en_q <= tx_en_d;
      if (advance) begin
        pend_valid_q <= accept;
        out_valid_q  <= pend_valid_q;
      end
    end
  end

  assign rx_fill_ext = {{LevelW{1'b0}}, rx_fill};
  assign tx_fill_ext = {{LevelW{1'b0}}, tx_fill};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    if (advance && pend_valid_q) begin
      data_q      <= pend_q.rd_rx ? rx_rdata : (pend_q.rd_tx ? tx_rdata : '0);
      ok_q        <= pend_q.ok;
      over_q      <= pend_q.over;
      tx_active_q <= tx_en_q;
      rx_level_q  <= rx_fill_ext[LevelW-1:0];
      tx_level_q  <= tx_fill_ext[LevelW-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data_out     = data_q;
  assign out_o.ok           = ok_q;
  assign out_o.rx_overwrote = over_q;
  assign out_o.tx_active    = tx_active_q;
  assign out_o.rx_level     = rx_level_q;
  assign out_o.tx_level     = tx_level_q;

  a_put_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && pend_q.ok && (pend_q.cmd == CmdPut)) |-> tx_en_q)
    else $error("An accepted put left the transmit-active flag low.");

  a_drain_clears_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && (pend_q.cmd == CmdTxReady) && tx_empty) |-> !tx_en_q)
    else $error("Transmit-active flag stayed high with an empty transmit ring.");

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !(pend_q.rd_rx && pend_q.rd_tx))
    else $error("A request read both rings.");

endmodule
